// ===== sv/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants for the source token lexer
// Scanner states, token kind codes and character class helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package stl_pkg;

    localparam int unsigned POS_BITS_DEF  = 32;
    localparam int unsigned NEST_BITS_DEF = 8;

    typedef enum logic [5:0] {
        S_IDLE, S_IDENT, S_NUM_FIRST, S_NUM_INT, S_HEX_NEED, S_HEX_DIG,
        S_FRAC_NEED, S_FRAC_DIG, S_EXP_NEED, S_EXP_DIG, S_DOT1, S_DOT2,
        S_PLUS, S_MINUS, S_STAR, S_SLASH, S_PERCENT, S_TILDE, S_CARET,
        S_AMP, S_PIPE, S_EQ, S_BANG, S_LT, S_LT2, S_GT, S_GT2, S_LINE,
        S_BLOCK, S_CHAR_FIRST, S_CHAR_ESC, S_CHAR_HEX1, S_CHAR_HEX2,
        S_CHAR_CLOSE, S_STR_BODY, S_STR_ESC, S_STR_HEX1, S_STR_HEX2
    } scan_state_t;

    typedef enum logic [1:0] {
        PV_NONE  = 2'd0,
        PV_STAR  = 2'd1,
        PV_SLASH = 2'd2
    } prev_t;

    localparam logic [5:0] K_EOF = 6'd0, K_IDENT = 6'd1, K_INT = 6'd2,
        K_HEX = 6'd3, K_FLOAT = 6'd4, K_CHARLIT = 6'd5, K_STRING = 6'd6,
        K_INVALID = 6'd7, K_LPAREN = 6'd8, K_RPAREN = 6'd9, K_LBRACE = 6'd10,
        K_RBRACE = 6'd11, K_LBRACK = 6'd12, K_RBRACK = 6'd13,
        K_ELLIPSIS = 6'd14, K_DOT = 6'd15, K_COLON = 6'd16, K_COMMA = 6'd17,
        K_SEMI = 6'd18, K_AT = 6'd19, K_INC = 6'd20, K_ADDEQ = 6'd21,
        K_ADD = 6'd22, K_DEC = 6'd23, K_SUBEQ = 6'd24, K_ARROW = 6'd25,
        K_SUB = 6'd26, K_MULEQ = 6'd27, K_MUL = 6'd28, K_DIVEQ = 6'd29,
        K_DIV = 6'd30, K_MODEQ = 6'd31, K_MOD = 6'd32, K_NOTEQ_T = 6'd33,
        K_TILDE = 6'd34, K_XOREQ = 6'd35, K_XOR = 6'd36, K_ANDEQ = 6'd37,
        K_AND = 6'd38, K_OREQ = 6'd39, K_OR = 6'd40, K_EQEQ = 6'd41,
        K_ASSIGN = 6'd42, K_NE = 6'd43, K_SHLEQ = 6'd44, K_SHL = 6'd45,
        K_LE = 6'd46, K_LT = 6'd47, K_SHREQ = 6'd48, K_SHR = 6'd49,
        K_GE = 6'd50, K_GT = 6'd51;

    // kind given when a pending token ends before the current byte; eof = none
    function automatic logic [5:0] fallback_kind(input scan_state_t s);
        logic [5:0] k;
        k = K_EOF;
        case (s)
            S_IDENT:                  k = K_IDENT;
            S_NUM_FIRST, S_NUM_INT:   k = K_INT;
            S_HEX_DIG:                k = K_HEX;
            S_FRAC_DIG, S_EXP_DIG:    k = K_FLOAT;
            S_DOT1:    k = K_DOT;
            S_PLUS:    k = K_ADD;
            S_MINUS:   k = K_SUB;
            S_STAR:    k = K_MUL;
            S_SLASH:   k = K_DIV;
            S_PERCENT: k = K_MOD;
            S_TILDE:   k = K_TILDE;
            S_CARET:   k = K_XOR;
            S_AMP:     k = K_AND;
            S_PIPE:    k = K_OR;
            S_EQ:      k = K_ASSIGN;
            S_LT:      k = K_LT;
            S_LT2:     k = K_SHL;
            S_GT:      k = K_GT;
            S_GT2:     k = K_SHR;
            S_HEX_NEED, S_FRAC_NEED, S_EXP_NEED, S_DOT2, S_BANG,
            S_CHAR_FIRST, S_CHAR_ESC, S_CHAR_HEX1, S_CHAR_HEX2,
            S_CHAR_CLOSE, S_STR_BODY, S_STR_ESC, S_STR_HEX1,
            S_STR_HEX2: k = K_INVALID;
            default:   k = K_EOF;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] eq_kind(input scan_state_t s);
        logic [5:0] k;
        k = K_INVALID;
        case (s)
            S_STAR:    k = K_MULEQ;
            S_PERCENT: k = K_MODEQ;
            S_TILDE:   k = K_NOTEQ_T;
            S_CARET:   k = K_XOREQ;
            S_AMP:     k = K_ANDEQ;
            S_PIPE:    k = K_OREQ;
            S_EQ:      k = K_EQEQ;
            S_BANG:    k = K_NE;
            default:   k = K_INVALID;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        logic [7:0] l;
        l = b | 8'h20;
        return ((l >= "a") && (l <= "z")) || (b == "_");
    endfunction

    function automatic logic is_xdigit(input logic [7:0] b);
        logic [7:0] l;
        l = b | 8'h20;
        return is_digit(b) || ((l >= "a") && (l <= "f"));
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

    function automatic logic is_ctrl(input logic [7:0] b);
        return (b < 8'd32) || (b == 8'd127);
    endfunction

    function automatic logic is_escape(input logic [7:0] b);
        logic r;
        case (b)
            "0", "a", "b", "e", "f", "n", "r", "t", "v", "\\", "'", "\"": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // idle-state dispatch: next state, or a one-byte token kind
    typedef struct packed {
        logic        done;   // single-byte token finished
        logic [5:0]  kind;
        scan_state_t nxt;
    } idle_res_t;

    function automatic idle_res_t idle_scan(input logic [7:0] b);
        idle_res_t r;
        r.done = 1'b0;
        r.kind = K_INVALID;
        r.nxt  = S_IDLE;
        if (is_space(b)) begin
            r.nxt = S_IDLE;
        end else if (is_letter(b)) begin
            r.nxt = S_IDENT;
        end else if (is_digit(b)) begin
            r.nxt = S_NUM_FIRST;
        end else begin
            case (b)
                "(": begin r.done = 1'b1; r.kind = K_LPAREN; end
                ")": begin r.done = 1'b1; r.kind = K_RPAREN; end
                "{": begin r.done = 1'b1; r.kind = K_LBRACE; end
                "}": begin r.done = 1'b1; r.kind = K_RBRACE; end
                "[": begin r.done = 1'b1; r.kind = K_LBRACK; end
                "]": begin r.done = 1'b1; r.kind = K_RBRACK; end
                ":": begin r.done = 1'b1; r.kind = K_COLON; end
                ",": begin r.done = 1'b1; r.kind = K_COMMA; end
                ";": begin r.done = 1'b1; r.kind = K_SEMI; end
                "@": begin r.done = 1'b1; r.kind = K_AT; end
                ".": r.nxt = S_DOT1;
                "+": r.nxt = S_PLUS;
                "-": r.nxt = S_MINUS;
                "*": r.nxt = S_STAR;
                "/": r.nxt = S_SLASH;
                "%": r.nxt = S_PERCENT;
                "~": r.nxt = S_TILDE;
                "^": r.nxt = S_CARET;
                "&": r.nxt = S_AMP;
                "|": r.nxt = S_PIPE;
                "=": r.nxt = S_EQ;
                "!": r.nxt = S_BANG;
                "<": r.nxt = S_LT;
                ">": r.nxt = S_GT;
                "'": r.nxt = S_CHAR_FIRST;
                "\"": r.nxt = S_STR_BODY;
                default: begin r.done = 1'b1; r.kind = K_INVALID; end
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/stl_scan.sv =====
// ----------------------------------------------------------------------------
// stl_scan: per-byte scanner next-state logic
// Combinational step for one byte: up to two tokens and the new state.
// ----------------------------------------------------------------------------
`default_nettype none
module stl_scan #(
    parameter int unsigned POS_BITS  = stl_pkg::POS_BITS_DEF,
    parameter int unsigned NEST_BITS = stl_pkg::NEST_BITS_DEF
) (
    input  wire stl_pkg::scan_state_t st,
    input  wire [POS_BITS-1:0]        tok_start,
    input  wire [POS_BITS-1:0]        cur_pos,
    input  wire [NEST_BITS-1:0]       depth,
    input  wire stl_pkg::prev_t       prev,
    input  wire [7:0]                 b,
    input  wire                       end_mark,
    output stl_pkg::scan_state_t      st_next,
    output logic [POS_BITS-1:0]       tok_start_next,
    output logic [POS_BITS-1:0]       cur_pos_next,
    output logic [NEST_BITS-1:0]      depth_next,
    output stl_pkg::prev_t            prev_next,
    output logic [1:0]                n_tok,
    output logic [5:0]                kind0,
    output logic [POS_BITS-1:0]       start0,
    output logic [POS_BITS-1:0]       len0,
    output logic [5:0]                kind1,
    output logic [POS_BITS-1:0]       start1,
    output logic [POS_BITS-1:0]       len1
);
    localparam logic [NEST_BITS-1:0] DEPTH_MAX = '1;

    logic [POS_BITS-1:0] nx;
    logic                take;      // pending state consumed the byte
    logic                fin;       // pending state finished with the byte
    logic [5:0]          fin_kind;
    stl_pkg::scan_state_t st_a;
    stl_pkg::idle_res_t  ir;

    assign nx = cur_pos + POS_BITS'(1);
    assign ir = stl_pkg::idle_scan(b);

    // first pass: the pending state looks at the byte
    always_comb begin
        take       = 1'b1;
        fin        = 1'b0;
        fin_kind   = stl_pkg::K_INVALID;
        st_a       = st;
        depth_next = depth;
        prev_next  = prev;
        unique case (st)
            stl_pkg::S_IDLE: take = 1'b0;
            stl_pkg::S_IDENT: take = stl_pkg::is_letter(b) || stl_pkg::is_digit(b);
            stl_pkg::S_NUM_FIRST, stl_pkg::S_NUM_INT: begin
                if (st == stl_pkg::S_NUM_FIRST && b == "x") st_a = stl_pkg::S_HEX_NEED;
                else if (stl_pkg::is_digit(b)) st_a = stl_pkg::S_NUM_INT;
                else if (b == ".") st_a = stl_pkg::S_FRAC_NEED;
                else take = 1'b0;
            end
            stl_pkg::S_HEX_NEED, stl_pkg::S_HEX_DIG: begin
                if (stl_pkg::is_xdigit(b)) st_a = stl_pkg::S_HEX_DIG;
                else take = 1'b0;
            end
            stl_pkg::S_FRAC_NEED, stl_pkg::S_FRAC_DIG: begin
                if (stl_pkg::is_digit(b)) st_a = stl_pkg::S_FRAC_DIG;
                else if (st == stl_pkg::S_FRAC_DIG && b == "e") st_a = stl_pkg::S_EXP_NEED;
                else take = 1'b0;
            end
            stl_pkg::S_EXP_NEED, stl_pkg::S_EXP_DIG: begin
                if (stl_pkg::is_digit(b)) st_a = stl_pkg::S_EXP_DIG;
                else take = 1'b0;
            end
            stl_pkg::S_DOT1: begin
                if (b == ".") st_a = stl_pkg::S_DOT2;
                else take = 1'b0;
            end
            stl_pkg::S_DOT2: begin
                if (b == ".") begin fin = 1'b1; fin_kind = stl_pkg::K_ELLIPSIS; end
                else take = 1'b0;
            end
            stl_pkg::S_PLUS: begin
                if (b == "+") begin fin = 1'b1; fin_kind = stl_pkg::K_INC; end
                else if (b == "=") begin fin = 1'b1; fin_kind = stl_pkg::K_ADDEQ; end
                else take = 1'b0;
            end
            stl_pkg::S_MINUS: begin
                if (b == "-") begin fin = 1'b1; fin_kind = stl_pkg::K_DEC; end
                else if (b == "=") begin fin = 1'b1; fin_kind = stl_pkg::K_SUBEQ; end
                else if (b == ">") begin fin = 1'b1; fin_kind = stl_pkg::K_ARROW; end
                else take = 1'b0;
            end
            stl_pkg::S_SLASH: begin
                if (b == "=") begin fin = 1'b1; fin_kind = stl_pkg::K_DIVEQ; end
                else if (b == "/") st_a = stl_pkg::S_LINE;
                else if (b == "*") begin
                    st_a       = stl_pkg::S_BLOCK;
                    depth_next = NEST_BITS'(1);
                    prev_next  = stl_pkg::PV_NONE;
                end else take = 1'b0;
            end
            stl_pkg::S_STAR, stl_pkg::S_PERCENT, stl_pkg::S_TILDE, stl_pkg::S_CARET,
            stl_pkg::S_AMP, stl_pkg::S_PIPE, stl_pkg::S_EQ, stl_pkg::S_BANG: begin
                if (b == "=") begin fin = 1'b1; fin_kind = stl_pkg::eq_kind(st); end
                else take = 1'b0;
            end
            stl_pkg::S_LT: begin
                if (b == "<") st_a = stl_pkg::S_LT2;
                else if (b == "=") begin fin = 1'b1; fin_kind = stl_pkg::K_LE; end
                else take = 1'b0;
            end
            stl_pkg::S_LT2: begin
                if (b == "=") begin fin = 1'b1; fin_kind = stl_pkg::K_SHLEQ; end
                else take = 1'b0;
            end
            stl_pkg::S_GT: begin
                if (b == ">") st_a = stl_pkg::S_GT2;
                else if (b == "=") begin fin = 1'b1; fin_kind = stl_pkg::K_GE; end
                else take = 1'b0;
            end
            stl_pkg::S_GT2: begin
                if (b == "=") begin fin = 1'b1; fin_kind = stl_pkg::K_SHREQ; end
                else take = 1'b0;
            end
            stl_pkg::S_LINE: if (b == 8'h0A) st_a = stl_pkg::S_IDLE;
            stl_pkg::S_BLOCK: begin
                if (prev == stl_pkg::PV_STAR && b == "/") begin
                    if (depth <= NEST_BITS'(1)) begin
                        depth_next = '0;
                        st_a       = stl_pkg::S_IDLE;
                    end else begin
                        depth_next = depth - NEST_BITS'(1);
                    end
                end else if (prev == stl_pkg::PV_SLASH && b == "*") begin
                    if (depth != DEPTH_MAX) depth_next = depth + NEST_BITS'(1);
                end
                if (st_a == stl_pkg::S_IDLE) prev_next = stl_pkg::PV_NONE;
                else if (b == "*") prev_next = stl_pkg::PV_STAR;
                else if (b == "/") prev_next = stl_pkg::PV_SLASH;
                else prev_next = stl_pkg::PV_NONE;
            end
            stl_pkg::S_CHAR_FIRST: begin
                if (b == "\\") st_a = stl_pkg::S_CHAR_ESC;
                else if (stl_pkg::is_ctrl(b)) fin = 1'b1;
                else st_a = stl_pkg::S_CHAR_CLOSE;
            end
            stl_pkg::S_CHAR_ESC, stl_pkg::S_STR_ESC: begin
                if (stl_pkg::is_escape(b))
                    st_a = (st == stl_pkg::S_CHAR_ESC) ? stl_pkg::S_CHAR_CLOSE
                                                       : stl_pkg::S_STR_BODY;
                else if (b == "x")
                    st_a = (st == stl_pkg::S_CHAR_ESC) ? stl_pkg::S_CHAR_HEX1
                                                       : stl_pkg::S_STR_HEX1;
                else fin = 1'b1;
            end
            stl_pkg::S_CHAR_HEX1, stl_pkg::S_STR_HEX1: begin
                if (stl_pkg::is_xdigit(b))
                    st_a = (st == stl_pkg::S_CHAR_HEX1) ? stl_pkg::S_CHAR_HEX2
                                                        : stl_pkg::S_STR_HEX2;
                else fin = 1'b1;
            end
            stl_pkg::S_CHAR_HEX2, stl_pkg::S_STR_HEX2: begin
                if (stl_pkg::is_xdigit(b))
                    st_a = (st == stl_pkg::S_CHAR_HEX2) ? stl_pkg::S_CHAR_CLOSE
                                                        : stl_pkg::S_STR_BODY;
                else fin = 1'b1;
            end
            stl_pkg::S_CHAR_CLOSE: begin
                fin = 1'b1;
                fin_kind = (b == "'") ? stl_pkg::K_CHARLIT : stl_pkg::K_INVALID;
            end
            stl_pkg::S_STR_BODY: begin
                if (b == "\"") begin fin = 1'b1; fin_kind = stl_pkg::K_STRING; end
                else if (stl_pkg::is_ctrl(b)) fin = 1'b1;
                else if (b == "\\") st_a = stl_pkg::S_STR_ESC;
            end
            default: take = 1'b0;
        endcase
    end

    // combine: end mark flush, consumed byte, or rejected byte rescanned from idle
    always_comb begin
        n_tok          = 2'd0;
        kind0          = stl_pkg::K_EOF;
        start0         = tok_start;
        len0           = '0;
        kind1          = stl_pkg::K_EOF;
        start1         = cur_pos;
        len1           = '0;
        st_next        = st;
        tok_start_next = tok_start;
        cur_pos_next   = nx;
        if (end_mark) begin
            cur_pos_next   = cur_pos;
            tok_start_next = cur_pos;
            st_next        = stl_pkg::S_IDLE;
            if (stl_pkg::fallback_kind(st) != stl_pkg::K_EOF) begin
                n_tok  = 2'd2;
                kind0  = stl_pkg::fallback_kind(st);
                len0   = cur_pos - tok_start;
                kind1  = stl_pkg::K_EOF;
                start1 = cur_pos;
            end else begin
                n_tok  = 2'd1;
                kind0  = stl_pkg::K_EOF;
                start0 = cur_pos;
            end
        end else if (take) begin
            if (fin) begin
                n_tok   = 2'd1;
                kind0   = fin_kind;
                len0    = nx - tok_start;
                st_next = stl_pkg::S_IDLE;
            end else begin
                st_next = st_a;
            end
        end else begin
            // token (if any) ends before this byte; byte restarts from idle
            tok_start_next = cur_pos;
            st_next        = ir.nxt;
            if (st != stl_pkg::S_IDLE) begin
                kind0 = stl_pkg::fallback_kind(st);
                len0  = cur_pos - tok_start;
                if (ir.done) begin
                    n_tok   = 2'd2;
                    kind1   = ir.kind;
                    start1  = cur_pos;
                    len1    = POS_BITS'(1);
                    st_next = stl_pkg::S_IDLE;
                end else begin
                    n_tok = 2'd1;
                end
            end else if (ir.done) begin
                n_tok   = 2'd1;
                kind0   = ir.kind;
                start0  = cur_pos;
                len0    = POS_BITS'(1);
                st_next = stl_pkg::S_IDLE;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/source_token_lexer_top.sv =====
// ----------------------------------------------------------------------------
// source_token_lexer_top: streaming lexer for C-like source text
// Bytes in, tokens (kind, start, length) out over stream channels.
// ----------------------------------------------------------------------------
// Usage: one source byte is taken per cycle whenever the output side keeps
// up; each word can cause up to two tokens (a pending token closed by the
// byte plus a one-byte token, or a flushed token plus eof on the end mark).
// The scanner state is registered from the input word, and the
// tokens go into a two-entry output queue; s_axis_tready is high while
// that queue has room for two tokens, so the sustained rate is one byte
// per cycle and drops only when the consumer stalls or a byte yields two
// tokens back to back.
`default_nettype none
module source_token_lexer_top #(
    parameter int unsigned POS_BITS  = stl_pkg::POS_BITS_DEF,
    parameter int unsigned NEST_BITS = stl_pkg::NEST_BITS_DEF
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [7:0]  s_axis_tdata,   // [7:0] source_byte
    input  wire        s_axis_tuser,   // end_mark
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // [5:0] token_kind, [37:6] start_pos,
                                       // [69:38] token_len, [71:70] zero
    output logic       m_axis_tlast    // last
);
    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [31:0] len;
        logic        last;
    } tok_t;

    stl_pkg::scan_state_t st_reg, st_next;
    logic [POS_BITS-1:0]  tok_start_reg, tok_start_next;
    logic [POS_BITS-1:0]  cur_pos_reg, cur_pos_next;
    logic [NEST_BITS-1:0] depth_reg, depth_next;
    stl_pkg::prev_t       prev_reg, prev_next;

    logic [1:0]          n_tok;
    logic [5:0]          kind0, kind1;
    logic [POS_BITS-1:0] start0, len0, start1, len1;

    // output queue: two entries, q_reg[0] is the head
    tok_t       q_reg [2];
    tok_t       q_next [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       acc, pop;
    tok_t       t0, t1;

    stl_scan #(.POS_BITS(POS_BITS), .NEST_BITS(NEST_BITS)) u_scan (
        .st(st_reg), .tok_start(tok_start_reg), .cur_pos(cur_pos_reg),
        .depth(depth_reg), .prev(prev_reg), .b(s_axis_tdata),
        .end_mark(s_axis_tuser), .st_next(st_next),
        .tok_start_next(tok_start_next), .cur_pos_next(cur_pos_next),
        .depth_next(depth_next), .prev_next(prev_next), .n_tok(n_tok),
        .kind0(kind0), .start0(start0), .len0(len0),
        .kind1(kind1), .start1(start1), .len1(len1)
    );

    assign pop           = m_axis_tvalid && m_axis_tready;
    // room for two after the head word leaves this cycle
    assign s_axis_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_axis_tready);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = cnt_reg != 2'd0;
    assign m_axis_tdata  = {2'b00, q_reg[0].len, q_reg[0].start, q_reg[0].kind};
    assign m_axis_tlast  = q_reg[0].last;

    always_comb begin
        t0.kind  = kind0;
        t0.start = 32'(start0);
        t0.len   = 32'(len0);
        t0.last  = (n_tok == 2'd1);
        t1.kind  = kind1;
        t1.start = 32'(start1);
        t1.len   = 32'(len1);
        t1.last  = 1'b1;
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        cnt_next  = cnt_reg;
        if (pop) begin
            q_next[0] = q_reg[1];
            cnt_next  = cnt_reg - 2'd1;
        end
        // accept only happens when the queue is empty after this pop
        if (acc && n_tok != 2'd0) begin
            q_next[0] = t0;
            q_next[1] = t1;
            cnt_next  = n_tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= stl_pkg::S_IDLE;
            tok_start_reg <= '0;
            cur_pos_reg   <= '0;
            depth_reg     <= '0;
            prev_reg      <= stl_pkg::PV_NONE;
            cnt_reg       <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (acc) begin
                st_reg        <= st_next;
                tok_start_reg <= tok_start_next;
                cur_pos_reg   <= cur_pos_next;
                depth_reg     <= s_axis_tuser ? '0 : depth_next;
                prev_reg      <= s_axis_tuser ? stl_pkg::PV_NONE : prev_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

endmodule
`default_nettype wire

// ===== sv/stl_checker.sv =====
// ----------------------------------------------------------------------------
// stl_checker: port-level checks for the source token lexer
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module stl_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        s_axis_tuser,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [71:0] m_axis_tdata,
    input wire        m_axis_tlast
);
    // an end mark always yields a word right after it
    a_end_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> m_axis_tvalid)
        else $error("no token after end mark");

    // eof words carry zero length
    a_eof_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[5:0] == 6'd0) |-> (m_axis_tdata[69:38] == 32'd0))
        else $error("eof with nonzero length");

    // eof is always the last word of its group
    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[5:0] == 6'd0) |-> m_axis_tlast)
        else $error("eof without last");

    // stalled output word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output word changed under stall");
endmodule

bind source_token_lexer_top stl_checker u_stl_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for source_token_lexer_top
// Streams directed and random source text through the lexer, predicts the
// token stream with an independent scanner model and checks every token.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [31:0] len;
        logic        last;
    } token_t;

    int unsigned n_errors = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_v);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, exp_v);
        n_errors++;
    endtask

    // Scanner model plus queue of predicted tokens.
    class token_scoreboard;
        stl_pkg::scan_state_t st;
        logic [31:0] tok_start, pos;
        logic [7:0]  depth;
        stl_pkg::prev_t prev;
        token_t      pending[$];
        token_t      step_out[$];

        function new();
            st = stl_pkg::S_IDLE; tok_start = 0; pos = 0; depth = 0;
            prev = stl_pkg::PV_NONE;
        endfunction

        function void push(logic [5:0] k, logic [31:0] stop);
            token_t t;
            if (step_out.size() >= 2) return;
            t.kind = k; t.start = tok_start; t.len = stop - tok_start; t.last = 0;
            step_out.push_back(t);
        endfunction

        function void close_tok(logic [5:0] k, logic [31:0] stop);
            push(k, stop);
            st = stl_pkg::S_IDLE;
        endfunction

        function logic xd(logic [7:0] b);
            logic [7:0] l;
            l = b | 8'h20;
            return (b >= "0" && b <= "9") || (l >= "a" && l <= "f");
        endfunction

        function logic ctl(logic [7:0] b);
            return b < 8'd32 || b == 8'd127;
        endfunction

        function logic esc_ok(logic [7:0] b);
            return b inside {"0", "a", "b", "e", "f", "n", "r", "t", "v", "\\", "'", "\""};
        endfunction

        function logic [5:0] flush_kind(stl_pkg::scan_state_t s);
            case (s)
                stl_pkg::S_IDENT: return stl_pkg::K_IDENT;
                stl_pkg::S_NUM_FIRST, stl_pkg::S_NUM_INT: return stl_pkg::K_INT;
                stl_pkg::S_HEX_DIG: return stl_pkg::K_HEX;
                stl_pkg::S_FRAC_DIG, stl_pkg::S_EXP_DIG: return stl_pkg::K_FLOAT;
                stl_pkg::S_DOT1: return stl_pkg::K_DOT;
                stl_pkg::S_PLUS: return stl_pkg::K_ADD;
                stl_pkg::S_MINUS: return stl_pkg::K_SUB;
                stl_pkg::S_STAR: return stl_pkg::K_MUL;
                stl_pkg::S_SLASH: return stl_pkg::K_DIV;
                stl_pkg::S_PERCENT: return stl_pkg::K_MOD;
                stl_pkg::S_TILDE: return stl_pkg::K_TILDE;
                stl_pkg::S_CARET: return stl_pkg::K_XOR;
                stl_pkg::S_AMP: return stl_pkg::K_AND;
                stl_pkg::S_PIPE: return stl_pkg::K_OR;
                stl_pkg::S_EQ: return stl_pkg::K_ASSIGN;
                stl_pkg::S_LT: return stl_pkg::K_LT;
                stl_pkg::S_LT2: return stl_pkg::K_SHL;
                stl_pkg::S_GT: return stl_pkg::K_GT;
                stl_pkg::S_GT2: return stl_pkg::K_SHR;
                stl_pkg::S_IDLE, stl_pkg::S_LINE, stl_pkg::S_BLOCK: return stl_pkg::K_EOF;
                default: return stl_pkg::K_INVALID;
            endcase
        endfunction

        // returns 0 when the byte must be rescanned from idle
        function logic scan(logic [7:0] b, logic [31:0] p);
            logic [31:0] nx;
            logic [7:0]  l;
            nx = p + 1;
            l = b | 8'h20;
            case (st)
                stl_pkg::S_IDLE: begin
                    tok_start = p;
                    if (b == " " || (b >= 9 && b <= 13)) return 1;
                    if ((l >= "a" && l <= "z") || b == "_") begin
                        st = stl_pkg::S_IDENT; return 1;
                    end
                    if (b >= "0" && b <= "9") begin st = stl_pkg::S_NUM_FIRST; return 1; end
                    case (b)
                        "(": close_tok(stl_pkg::K_LPAREN, nx);
                        ")": close_tok(stl_pkg::K_RPAREN, nx);
                        "{": close_tok(stl_pkg::K_LBRACE, nx);
                        "}": close_tok(stl_pkg::K_RBRACE, nx);
                        "[": close_tok(stl_pkg::K_LBRACK, nx);
                        "]": close_tok(stl_pkg::K_RBRACK, nx);
                        ":": close_tok(stl_pkg::K_COLON, nx);
                        ",": close_tok(stl_pkg::K_COMMA, nx);
                        ";": close_tok(stl_pkg::K_SEMI, nx);
                        "@": close_tok(stl_pkg::K_AT, nx);
                        ".": st = stl_pkg::S_DOT1;
                        "+": st = stl_pkg::S_PLUS;
                        "-": st = stl_pkg::S_MINUS;
                        "*": st = stl_pkg::S_STAR;
                        "/": st = stl_pkg::S_SLASH;
                        "%": st = stl_pkg::S_PERCENT;
                        "~": st = stl_pkg::S_TILDE;
                        "^": st = stl_pkg::S_CARET;
                        "&": st = stl_pkg::S_AMP;
                        "|": st = stl_pkg::S_PIPE;
                        "=": st = stl_pkg::S_EQ;
                        "!": st = stl_pkg::S_BANG;
                        "<": st = stl_pkg::S_LT;
                        ">": st = stl_pkg::S_GT;
                        "'": st = stl_pkg::S_CHAR_FIRST;
                        "\"": st = stl_pkg::S_STR_BODY;
                        default: close_tok(stl_pkg::K_INVALID, nx);
                    endcase
                    return 1;
                end
                stl_pkg::S_IDENT:
                    if ((l >= "a" && l <= "z") || b == "_" || (b >= "0" && b <= "9"))
                        return 1;
                stl_pkg::S_NUM_FIRST, stl_pkg::S_NUM_INT: begin
                    if (st == stl_pkg::S_NUM_FIRST && b == "x") begin
                        st = stl_pkg::S_HEX_NEED; return 1;
                    end
                    if (b >= "0" && b <= "9") begin st = stl_pkg::S_NUM_INT; return 1; end
                    if (b == ".") begin st = stl_pkg::S_FRAC_NEED; return 1; end
                end
                stl_pkg::S_HEX_NEED, stl_pkg::S_HEX_DIG:
                    if (xd(b)) begin st = stl_pkg::S_HEX_DIG; return 1; end
                stl_pkg::S_FRAC_NEED, stl_pkg::S_FRAC_DIG: begin
                    if (b >= "0" && b <= "9") begin st = stl_pkg::S_FRAC_DIG; return 1; end
                    if (st == stl_pkg::S_FRAC_DIG && b == "e") begin
                        st = stl_pkg::S_EXP_NEED; return 1;
                    end
                end
                stl_pkg::S_EXP_NEED, stl_pkg::S_EXP_DIG:
                    if (b >= "0" && b <= "9") begin st = stl_pkg::S_EXP_DIG; return 1; end
                stl_pkg::S_DOT1: if (b == ".") begin st = stl_pkg::S_DOT2; return 1; end
                stl_pkg::S_DOT2:
                    if (b == ".") begin close_tok(stl_pkg::K_ELLIPSIS, nx); return 1; end
                stl_pkg::S_PLUS: begin
                    if (b == "+") begin close_tok(stl_pkg::K_INC, nx); return 1; end
                    if (b == "=") begin close_tok(stl_pkg::K_ADDEQ, nx); return 1; end
                end
                stl_pkg::S_MINUS: begin
                    if (b == "-") begin close_tok(stl_pkg::K_DEC, nx); return 1; end
                    if (b == "=") begin close_tok(stl_pkg::K_SUBEQ, nx); return 1; end
                    if (b == ">") begin close_tok(stl_pkg::K_ARROW, nx); return 1; end
                end
                stl_pkg::S_SLASH: begin
                    if (b == "=") begin close_tok(stl_pkg::K_DIVEQ, nx); return 1; end
                    if (b == "/") begin st = stl_pkg::S_LINE; return 1; end
                    if (b == "*") begin
                        st = stl_pkg::S_BLOCK; depth = 1; prev = stl_pkg::PV_NONE; return 1;
                    end
                end
                stl_pkg::S_STAR:
                    if (b == "=") begin close_tok(stl_pkg::K_MULEQ, nx); return 1; end
                stl_pkg::S_PERCENT:
                    if (b == "=") begin close_tok(stl_pkg::K_MODEQ, nx); return 1; end
                stl_pkg::S_TILDE:
                    if (b == "=") begin close_tok(stl_pkg::K_NOTEQ_T, nx); return 1; end
                stl_pkg::S_CARET:
                    if (b == "=") begin close_tok(stl_pkg::K_XOREQ, nx); return 1; end
                stl_pkg::S_AMP:
                    if (b == "=") begin close_tok(stl_pkg::K_ANDEQ, nx); return 1; end
                stl_pkg::S_PIPE:
                    if (b == "=") begin close_tok(stl_pkg::K_OREQ, nx); return 1; end
                stl_pkg::S_EQ:
                    if (b == "=") begin close_tok(stl_pkg::K_EQEQ, nx); return 1; end
                stl_pkg::S_BANG:
                    if (b == "=") begin close_tok(stl_pkg::K_NE, nx); return 1; end
                stl_pkg::S_LT: begin
                    if (b == "<") begin st = stl_pkg::S_LT2; return 1; end
                    if (b == "=") begin close_tok(stl_pkg::K_LE, nx); return 1; end
                end
                stl_pkg::S_LT2:
                    if (b == "=") begin close_tok(stl_pkg::K_SHLEQ, nx); return 1; end
                stl_pkg::S_GT: begin
                    if (b == ">") begin st = stl_pkg::S_GT2; return 1; end
                    if (b == "=") begin close_tok(stl_pkg::K_GE, nx); return 1; end
                end
                stl_pkg::S_GT2:
                    if (b == "=") begin close_tok(stl_pkg::K_SHREQ, nx); return 1; end
                stl_pkg::S_LINE: begin
                    if (b == 8'h0a) st = stl_pkg::S_IDLE;
                    return 1;
                end
                stl_pkg::S_BLOCK: begin
                    if (prev == stl_pkg::PV_STAR && b == "/") begin
                        if (depth != 0) depth--;
                        if (depth == 0) begin
                            prev = stl_pkg::PV_NONE; st = stl_pkg::S_IDLE; return 1;
                        end
                    end else if (prev == stl_pkg::PV_SLASH && b == "*") begin
                        if (depth != 8'hff) depth++;
                    end
                    prev = (b == "*") ? stl_pkg::PV_STAR :
                           (b == "/") ? stl_pkg::PV_SLASH : stl_pkg::PV_NONE;
                    return 1;
                end
                stl_pkg::S_CHAR_FIRST: begin
                    if (b == "\\") st = stl_pkg::S_CHAR_ESC;
                    else if (ctl(b)) close_tok(stl_pkg::K_INVALID, nx);
                    else st = stl_pkg::S_CHAR_CLOSE;
                    return 1;
                end
                stl_pkg::S_CHAR_ESC, stl_pkg::S_STR_ESC: begin
                    if (esc_ok(b))
                        st = (st == stl_pkg::S_CHAR_ESC) ? stl_pkg::S_CHAR_CLOSE
                                                         : stl_pkg::S_STR_BODY;
                    else if (b == "x")
                        st = (st == stl_pkg::S_CHAR_ESC) ? stl_pkg::S_CHAR_HEX1
                                                         : stl_pkg::S_STR_HEX1;
                    else close_tok(stl_pkg::K_INVALID, nx);
                    return 1;
                end
                stl_pkg::S_CHAR_HEX1, stl_pkg::S_STR_HEX1: begin
                    if (xd(b))
                        st = (st == stl_pkg::S_CHAR_HEX1) ? stl_pkg::S_CHAR_HEX2
                                                          : stl_pkg::S_STR_HEX2;
                    else close_tok(stl_pkg::K_INVALID, nx);
                    return 1;
                end
                stl_pkg::S_CHAR_HEX2, stl_pkg::S_STR_HEX2: begin
                    if (xd(b))
                        st = (st == stl_pkg::S_CHAR_HEX2) ? stl_pkg::S_CHAR_CLOSE
                                                          : stl_pkg::S_STR_BODY;
                    else close_tok(stl_pkg::K_INVALID, nx);
                    return 1;
                end
                stl_pkg::S_CHAR_CLOSE: begin
                    close_tok((b == "'") ? stl_pkg::K_CHARLIT : stl_pkg::K_INVALID, nx);
                    return 1;
                end
                stl_pkg::S_STR_BODY: begin
                    if (b == "\"") close_tok(stl_pkg::K_STRING, nx);
                    else if (ctl(b)) close_tok(stl_pkg::K_INVALID, nx);
                    else if (b == "\\") st = stl_pkg::S_STR_ESC;
                    return 1;
                end
                default: begin st = stl_pkg::S_IDLE; return 0; end
            endcase
            push(flush_kind(st), p);
            st = stl_pkg::S_IDLE;
            return 0;
        endfunction

        function void note_word(logic [7:0] b, logic endm);
            logic [5:0] k;
            step_out.delete();
            if (endm) begin
                k = flush_kind(st);
                if (k != stl_pkg::K_EOF) push(k, pos);
                tok_start = pos;
                push(stl_pkg::K_EOF, pos);
                st = stl_pkg::S_IDLE; depth = 0; prev = stl_pkg::PV_NONE;
            end else begin
                if (!scan(b, pos)) void'(scan(b, pos));
                pos = pos + 1;
            end
            if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1;
            foreach (step_out[i]) pending.push_back(step_out[i]);
        endfunction

        task check_token(logic [71:0] data, logic lst);
            token_t e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected token", data[63:0], 0);
                return;
            end
            e = pending.pop_front();
            if (data[5:0] != e.kind) report_mismatch("kind", data[5:0], e.kind);
            if (data[37:6] != e.start) report_mismatch("start", data[37:6], e.start);
            if (data[69:38] != e.len) report_mismatch("length", data[69:38], e.len);
            if (lst != e.last) report_mismatch("tlast", lst, e.last);
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 0;   // [7:0] source_byte
    logic        s_axis_tuser = 0;   // end_mark
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [71:0] m_axis_tdata;       // [5:0] kind, [37:6] start, [69:38] length
    logic        m_axis_tlast;

    token_scoreboard sb = new();
    bit          no_idle = 0;   // stretch with no gaps on either side

    source_token_lexer_top i_dut (
        .aclk, .aresetn,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Send one word; gaps of random length before it. tvalid stays high
    // between words sent back to back.
    task automatic send_word(input logic [7:0] b, input logic endm);
        while (!no_idle && $urandom_range(99) < 17) begin
            s_axis_tvalid <= 0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1; s_axis_tdata <= b; s_axis_tuser <= endm;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_word(b, endm);
        @(negedge aclk);
    endtask

    task automatic send_text(input string txt);
        foreach (txt[i]) send_word(txt[i], 0);
    endtask

    // Random pieces of well-formed text mixed with noise.
    task automatic send_fragment();
        string ops[$] = '{"(", ")", "{", "}", "[", "]", "...", ".", ":", ",", ";", "@",
            "++", "+=", "+", "--", "-=", "->", "-", "*=", "*", "/=", "/", "%=", "%",
            "~=", "~", "^=", "^", "&=", "&", "|=", "|", "==", "=", "!=", "!", "<<=",
            "<<", "<=", "<", ">>=", ">>", ">=", ">", ".."};
        string s;
        int n;
        s = "";
        case ($urandom_range(11))
            0: begin
                n = $urandom_range(1, 6);
                repeat (n) s = {s, string'(8'($urandom_range(0, 1) ? "a" + $urandom_range(25)
                                  : "0" + $urandom_range(9)))};
                s = {"_", s};
            end
            1: s = $sformatf("%0d", $urandom);
            2: s = $sformatf("0x%0h", $urandom);
            3: s = $sformatf("%0d.%0de%0d", $urandom_range(99), $urandom_range(99),
                             $urandom_range(99));
            4: s = ops[$urandom_range(ops.size() - 1)];
            5: s = $urandom_range(1) ? "'a'" : "'\\x4F'";
            6: s = $urandom_range(1) ? "\"s \\n q\"" : "\"\\xAb\"";
            7: s = $urandom_range(1) ? "// line\n" : "/* a /* b */ c */";
            8: s = " ";
            9: send_word(8'($urandom_range(255)), 0);
            10: s = $urandom_range(1) ? "0x" : "1.e";
            default: if ($urandom_range(9) == 0) send_word(8'($urandom), 1);
                     else s = "\t\n";
        endcase
        if (s.len() > 0) send_text(s);
    endtask

    // Result side: random stalls, checks at the rising edge.
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_axis_tready <= no_idle || ($urandom_range(99) >= 17);
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) sb.check_token(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin
        int k;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // directed: every operator, numbers, literals, comments, odd cases
        send_text("a_Z9 0 123 0x1fA 1.5e10 1.5 ( ) { } [ ] ... .. . : , ; @ ");
        send_text("++ += + -- -= -> - *= * /= / %= % ~= ~ ^= ^ &= & |= | == = != ! ");
        send_text("<<= << <= < >>= >> >= > 'c' '\\n' '\\x41' 'ab \"ok\\t\\x7f\" ");
        send_text("0xg 1.x 1.5ex .x ! ` /* x /* y */ z */ // c\n \"a\001 '\\q ");
        send_word(8'hff, 0); send_word(8'h00, 0); send_word(8'h7f, 0);
        send_text("\"open");
        send_word(0, 1);
        send_word(8'hff, 1);
        // nested comments, left open at the end mark
        repeat (4) send_text("/*");
        repeat (3) send_text("*/");
        send_word(0, 1);
        for (k = 0; k < 85; k++) begin
            no_idle = (k >= 30 && k < 60);
            send_fragment();
        end
        no_idle = 0;
        send_word(8'h55, 1);
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (n_errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== source_token_lexer_top.f =====
sv/stl_pkg.sv
sv/stl_scan.sv
sv/source_token_lexer_top.sv
sv/stl_checker.sv
tb/testbench.sv
